### design/trd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trd_pkg
// shared types and constants of the record deframer
// ----------------------------------------------------------------------------
package trd_pkg;

    // record type byte expected after reset (application data)
    localparam logic [7:0] RECORD_TYPE_RESET = 8'h17;

    // header walk, one-hot
    typedef enum logic [6:0] {
        ST_TYPE    = 7'b0000001,
        ST_VER1    = 7'b0000010,
        ST_VER2    = 7'b0000100,
        ST_LEN_HI  = 7'b0001000,
        ST_LEN_LO  = 7'b0010000,
        ST_PAYLOAD = 7'b0100000,
        ST_HALT    = 7'b1000000
    } t_state;

    // one result word
    typedef struct packed {
        logic [7:0] payload_byte;
        logic       last_in_record;
        logic       framing_error;
    } t_result;

endpackage

### design/trd_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trd_parser
// record header walker: consumes one byte per advance, emits payload and error words
// ----------------------------------------------------------------------------
module trd_parser
    import trd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,       // byte held in input register
    input  logic [7:0] i_byte,
    input  logic [7:0] i_expected,    // required record type
    input  logic       i_out_free,    // result register can load
    output logic       o_advance,     // byte consumed this cycle
    output logic       o_res_valid,   // a result word is produced
    output t_result    o_res
);

    t_state      r_state,     n_state;
    logic [7:0]  r_len_hi,    n_len_hi;
    logic [15:0] r_remaining, n_remaining;
    logic        produces;

    // does the byte in hand make a result word
    always_comb begin
        produces = 1'b0;
        unique case (r_state)
            ST_VER1, ST_VER2, ST_LEN_HI, ST_LEN_LO, ST_HALT: produces = 1'b0;
            ST_PAYLOAD: produces = 1'b1;
            default:    produces = (i_byte != i_expected);
        endcase
    end

    assign o_advance   = i_valid && (!produces || i_out_free);
    assign o_res_valid = o_advance && produces;

    always_comb begin
        n_state     = r_state;
        n_len_hi    = r_len_hi;
        n_remaining = r_remaining;
        o_res       = '0;
        unique case (r_state)
            ST_VER1:   n_state = ST_VER2;
            ST_VER2:   n_state = ST_LEN_HI;
            ST_LEN_HI: begin
                n_len_hi = i_byte;
                n_state  = ST_LEN_LO;
            end
            ST_LEN_LO: begin
                n_remaining = {r_len_hi, i_byte};
                // empty record goes straight back to the type byte
                n_state = ({r_len_hi, i_byte} == 16'd0) ? ST_TYPE : ST_PAYLOAD;
            end
            ST_PAYLOAD: begin
                n_remaining          = r_remaining - 16'd1;
                o_res.payload_byte   = i_byte;
                o_res.last_in_record = (r_remaining == 16'd1);
                if (r_remaining == 16'd1) begin
                    n_state = ST_TYPE;
                end
            end
            ST_HALT: n_state = ST_HALT;
            default: begin
                if (i_byte != i_expected) begin
                    o_res.framing_error = 1'b1;
                    n_state = ST_HALT;
                end else begin
                    n_state = ST_VER1;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_TYPE;
            r_len_hi    <= 8'd0;
            r_remaining <= 16'd0;
        end else if (o_advance) begin
            r_state     <= n_state;
            r_len_hi    <= n_len_hi;
            r_remaining <= n_remaining;
        end
    end

    a_halt_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_HALT |=> r_state == ST_HALT)
        else $error("halt state left before reset");

    a_payload_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_PAYLOAD |-> r_remaining != 16'd0)
        else $error("payload state with nothing remaining");

    a_last_ends_record: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_advance && r_state == ST_PAYLOAD && r_remaining == 16'd1
        |=> r_state == ST_TYPE)
        else $error("record did not end after its last byte");

endmodule

### design/tls_app_record_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tls_app_record_deframer
// strips application-data record headers from a byte stream
// ----------------------------------------------------------------------------
// path: an accepted payload byte goes through the input register, then the
//   result register, to the master side; a busy master side holds it back
// throughput: one byte per cycle unless master stalls; single-pass header walker
// reset: synchronous active low; clears the header walk (with its halt state),
//   both valid flags and restores the expected type to 0x17
// ----------------------------------------------------------------------------
module tls_app_record_deframer
    import trd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    // configuration write channel
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [7:0] i_cfg_data,    // expected_record_type
    // slave side: framed byte stream
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,     // [7:0] data_byte
    // master side: payload words
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,     // [7:0] payload_byte
    output logic       o_m_tlast,     // last_in_record
    output logic       o_m_tuser      // [0] framing_error
);

    logic [7:0] r_expected;
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    t_result    r_out;
    logic       out_free;
    logic       advance;
    logic       res_valid;
    t_result    res;

    // register write is always taken; new value applies from the next type byte
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected <= RECORD_TYPE_RESET;
        end else if (i_cfg_valid) begin
            r_expected <= i_cfg_data;
        end
    end

    // result register is free when empty or being drained this cycle
    assign out_free   = !r_out_valid || i_m_tready;
    // input register refills while its byte moves on
    assign o_s_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_byte <= i_s_tdata;
        end
    end

    // header walk and payload count
    trd_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (r_in_valid),
        .i_byte      (r_in_byte),
        .i_expected  (r_expected),
        .i_out_free  (out_free),
        .o_advance   (advance),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // result register: header bytes and halted input leave it untouched
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_out <= res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out.payload_byte;
    assign o_m_tlast  = r_out.last_in_record;
    assign o_m_tuser  = r_out.framing_error;

    a_error_word_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |-> o_m_tdata == 8'd0 && !o_m_tlast)
        else $error("error word carries payload");

    a_in_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !advance |=> r_in_valid && $stable(r_in_byte))
        else $error("stalled input byte lost");

    a_nothing_after_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser && i_m_tready |=> !o_m_tvalid)
        else $error("word emitted after framing error");

endmodule

### sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the record deframer: framed byte streams go in on
// the slave side, a scoreboard walks the same headers and checks every
// payload or error word on the master side, mostly under random idling
// ----------------------------------------------------------------------------
module tb;
    import trd_pkg::*;

    localparam int LIMIT_CYCLES = 2_000_000;

    // walks record headers and keeps the payload words still owed
    class deframe_scoreboard;
        logic [7:0]  want_type;
        t_state      walk;
        logic [7:0]  len_hi;
        logic [15:0] remaining;
        t_result     pending[$];
        int          errors;
        int          checked;

        function new();
            want_type = RECORD_TYPE_RESET;
            walk      = ST_TYPE;
            len_hi    = 8'h00;
            remaining = 16'h0000;
            errors    = 0;
            checked   = 0;
        endfunction

        function void note_byte(logic [7:0] b);
            t_result w;
            case (walk)
                ST_HALT: ;
                ST_VER1: walk = ST_VER2;
                ST_VER2: walk = ST_LEN_HI;
                ST_LEN_HI: begin
                    len_hi = b;
                    walk   = ST_LEN_LO;
                end
                ST_LEN_LO: begin
                    remaining = {len_hi, b};
                    walk = (remaining == 16'h0000) ? ST_TYPE : ST_PAYLOAD;
                end
                ST_PAYLOAD: begin
                    remaining        = remaining - 16'd1;
                    w.payload_byte   = b;
                    w.last_in_record = (remaining == 16'h0000);
                    w.framing_error  = 1'b0;
                    pending.push_back(w);
                    if (remaining == 16'h0000) walk = ST_TYPE;
                end
                default: begin
                    if (b != want_type) begin
                        // bad type byte: one error word, then deaf until reset
                        walk             = ST_HALT;
                        w.payload_byte   = 8'h00;
                        w.last_in_record = 1'b0;
                        w.framing_error  = 1'b1;
                        pending.push_back(w);
                    end else begin
                        walk = ST_VER1;
                    end
                end
            endcase
        endfunction

        function void check_word(t_result got);
            t_result want;
            if (pending.size() == 0) begin
                $error("unexpected word: data %02h last %0b user %0b",
                       got.payload_byte, got.last_in_record, got.framing_error);
                errors++;
                return;
            end
            want = pending.pop_front();
            checked++;
            if (got.payload_byte !== want.payload_byte) begin
                $error("payload_byte: expected %02h, got %02h",
                       want.payload_byte, got.payload_byte);
                errors++;
            end
            if (got.last_in_record !== want.last_in_record) begin
                $error("last_in_record: expected %0b, got %0b",
                       want.last_in_record, got.last_in_record);
                errors++;
            end
            if (got.framing_error !== want.framing_error) begin
                $error("framing_error: expected %0b, got %0b",
                       want.framing_error, got.framing_error);
                errors++;
            end
        endfunction
    endclass

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic [7:0] i_cfg_data  = 8'h00;
    logic       i_s_tvalid  = 1'b0;
    logic       o_s_tready;
    logic [7:0] i_s_tdata   = 8'h00;
    logic       o_m_tvalid;
    logic       i_m_tready  = 1'b0;
    logic [7:0] o_m_tdata;
    logic       o_m_tlast;
    logic       o_m_tuser;

    deframe_scoreboard sb = new();

    bit         bursts_on    = 1'b1;
    int         stall_left   = 0;
    int         cycle_count  = 0;
    int         bytes_sent   = 0;
    int         records_sent = 0;
    int         cfg_writes   = 0;
    logic [7:0] cur_type     = RECORD_TYPE_RESET;

    tls_app_record_deframer i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),    // [7:0] data_byte
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),    // [7:0] payload_byte
        .o_m_tlast   (o_m_tlast),    // last_in_record
        .o_m_tuser   (o_m_tuser)     // [0] framing_error
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // run guard
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("status: fail");
            $finish;
        end
    end

    // master-side back-pressure in random bursts
    always @(posedge i_clk) begin
        if (!bursts_on) begin
            i_m_tready <= 1'b1;
        end else if (stall_left > 0) begin
            i_m_tready <= 1'b0;
            stall_left--;
        end else if ($urandom_range(0, 4) == 0) begin
            i_m_tready <= 1'b0;
            stall_left = $urandom_range(0, 4);
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    // monitor: handshakes sampled at the edge, before the new drive lands
    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) sb.want_type = i_cfg_data;
            if (i_s_tvalid && o_s_tready) sb.note_byte(i_s_tdata);
            if (o_m_tvalid && i_m_tready) begin
                got.payload_byte   = o_m_tdata;
                got.last_in_record = o_m_tlast;
                got.framing_error  = o_m_tuser;
                sb.check_word(got);
            end
        end
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (bursts_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 5);
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        bytes_sent++;
    endtask

    // type, two version bytes, big-endian length
    task automatic send_header(input logic [7:0] rec_type, input logic [15:0] len);
        send_byte(rec_type);
        send_byte(8'($urandom_range(0, 255)));
        send_byte(8'($urandom_range(0, 255)));
        send_byte(len[15:8]);
        send_byte(len[7:0]);
        records_sent++;
    endtask

    // stop the stream and let every owed word come out, plus pipeline slack
    task automatic drain();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_type(input logic [7:0] v);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        cur_type = v;
        cfg_writes++;
    endtask

    // well-formed records, mostly short, some empty, a few long
    task automatic random_phase(input int budget);
        int start;
        int len;
        int k;
        start = bytes_sent;
        while (bytes_sent - start < budget) begin
            case ($urandom_range(0, 19))
                0, 1:    len = 0;
                2:       len = $urandom_range(13, 300);
                default: len = $urandom_range(1, 12);
            endcase
            send_header(cur_type, len[15:0]);
            for (k = 0; k < len; k++) send_byte(8'($urandom_range(0, 255)));
        end
    endtask

    initial begin
        int k;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: one-byte record, empty record, write between payload bytes
        send_header(RECORD_TYPE_RESET, 16'd1);
        send_byte(8'h00);
        send_header(RECORD_TYPE_RESET, 16'd0);
        send_header(RECORD_TYPE_RESET, 16'd4);
        send_byte(8'hFF);
        send_byte(8'hA5);
        write_type(8'hFF);
        send_byte(8'h5A);
        send_byte(8'h01);

        // random records across several type settings
        random_phase(250);
        write_type(8'h00);
        random_phase(250);
        write_type(8'($urandom_range(1, 254)));
        random_phase(250);
        write_type(RECORD_TYPE_RESET);
        random_phase(250);

        // no idling from here on: a record with a nonzero length high byte
        bursts_on = 1'b0;
        send_header(cur_type, 16'd300);
        for (k = 0; k < 300; k++) send_byte(8'($urandom_range(0, 255)));

        // bad type byte halts the stream; later bytes and writes are ignored
        send_byte(cur_type ^ 8'($urandom_range(1, 255)));
        send_header(cur_type, 16'd3);
        for (k = 0; k < 3; k++) send_byte(8'($urandom_range(0, 255)));
        write_type(8'($urandom_range(0, 255)));
        send_header(cur_type, 16'd2);
        for (k = 0; k < 2; k++) send_byte(8'($urandom_range(0, 255)));
        drain();

        $display("sent %0d bytes in %0d records, %0d type writes, halt at the end",
                 bytes_sent, records_sent, cfg_writes);
        $display("checked %0d output words, %0d mismatches", sb.checked, sb.errors);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

### files.f
design/trd_pkg.sv
design/trd_parser.sv
design/tls_app_record_deframer.sv
sim/tb.sv
